@@ rtl/core/assert_macros.svh @@
// Shared assertion macros for the sender window block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sender window check failed");

// Invariant that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rn, cond) \
  `ASSERT_IMP(lbl, ck, rn, 1'b1, cond)

`endif

@@ rtl/core/gbns_pkg.sv @@
`default_nettype none

package gbns_pkg;

  // Field widths fixed by the channel format
  localparam int CMD_W      = 2;
  localparam int FLAG_W     = 16;
  localparam int SEQ_W      = 16;
  localparam int KIND_W     = 2;
  localparam int WSIZE_W    = 7;
  localparam int COUNT_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Results one item may cause at most
  localparam int RESULT_LIMIT = 64;

  // Parameter defaults
  localparam int MAX_WINDOW_DEF = 64;
  localparam int SEQ_BITS_DEF   = 16;

  // Register reset values
  localparam logic [WSIZE_W-1:0] WSIZE_RST = 7'd12;
  localparam logic [COUNT_W-1:0] COUNT_RST = 16'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEND = 2'd0,
    KIND_NONE = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WSIZE = 1'b0,
    REG_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PLAN,
    ST_SEND,
    ST_NOTE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic update;
    logic plan;
    logic emit_send;
    logic emit_note;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic at_last;
    logic has_range;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/gbns_in_if.sv @@
`default_nettype none

interface gbns_in_if;
  import gbns_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [FLAG_W-1:0] ack_flag;
  logic [SEQ_W-1:0]  ack_seq;

  modport source (output valid, output cmd, output ack_flag, output ack_seq, input ready);
  modport sink   (input valid, input cmd, input ack_flag, input ack_seq, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gbns_out_if.sv @@
`default_nettype none

interface gbns_out_if;
  import gbns_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SEQ_W-1:0]  send_seq;
  logic              last;

  modport source (output valid, output kind, output send_seq, output last, input ready);
  modport sink   (input valid, input kind, input send_seq, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gbns_ctrl.sv @@
`default_nettype none

module gbns_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire gbns_pkg::stat_t stat,
  output gbns_pkg::ctl_t       ctl
);
  import gbns_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_PLAN;
      end
      ST_PLAN: begin
        state_nxt = stat.has_range ? ST_SEND : ST_NOTE;
      end
      ST_SEND: begin
        if (stat.out_free && stat.at_last) state_nxt = ST_IDLE;
      end
      ST_NOTE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    in_ready      = 1'b0;
    ctl           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.latch = in_valid;
      end
      ST_UPDATE: begin
        ctl.update = 1'b1;
      end
      ST_PLAN: begin
        ctl.plan = 1'b1;
      end
      ST_SEND: begin
        ctl.emit_send = stat.out_free;
      end
      ST_NOTE: begin
        ctl.emit_note = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/gbns_dp.sv @@
`default_nettype none
`include "assert_macros.svh"

module gbns_dp #(
  parameter int MAX_WINDOW = gbns_pkg::MAX_WINDOW_DEF,
  parameter int SEQ_BITS   = gbns_pkg::SEQ_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // item fields
  input  wire logic [gbns_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [gbns_pkg::FLAG_W-1:0]     in_ack_flag,
  input  wire logic [gbns_pkg::SEQ_W-1:0]      in_ack_seq,
  // register writes
  input  wire logic                            cfg_we,
  input  wire logic [gbns_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [gbns_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // control
  input  wire gbns_pkg::ctl_t                  ctl,
  output gbns_pkg::stat_t                      stat,
  // result register
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [gbns_pkg::KIND_W-1:0]          out_kind,
  output logic [gbns_pkg::SEQ_W-1:0]           out_send_seq,
  output logic                                 out_last
);
  import gbns_pkg::*;

  localparam int SW      = SEQ_BITS + 1;
  localparam int WIN_CAP = (MAX_WINDOW < RESULT_LIMIT) ? MAX_WINDOW : RESULT_LIMIT;

  // Registers
  logic [WSIZE_W-1:0] wsize_r, wsize_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic               flag_zero_r, flag_zero_nxt;
  logic [SEQ_W-1:0]   ack_r, ack_nxt;
  logic [SW-1:0]      base_r, base_nxt;
  logic [SW-1:0]      edge_r, edge_nxt;
  logic [SW-1:0]      old_edge_r, old_edge_nxt;
  logic               active_r, active_nxt;
  logic               ok_r, ok_nxt;
  logic [SW-1:0]      cur_r, cur_nxt;
  logic [SW-1:0]      hi_r, hi_nxt;
  kind_t              note_kind_r, note_kind_nxt;
  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic [SEQ_W-1:0]   out_seq_r, out_seq_nxt;
  logic               out_last_r, out_last_nxt;

  // Derived values
  logic [WSIZE_W-1:0]    win;
  logic [SW-1:0]         win_sw;
  logic [COUNT_W-1:0]    count_eff;
  logic [SW+COUNT_W-1:0] cnt_ext;
  logic [SW-1:0]         cnt;
  logic [SW+SEQ_W-1:0]   ack_ext;
  logic [SW-1:0]         ack_sw;
  logic                  ack_ok;
  logic [SW-1:0]         top;
  logic [SW-1:0]         top_p1;
  logic                  retire;
  logic [SW-1:0]         edge_adv;
  logic [SW-1:0]         lo_a;
  logic [SW-1:0]         lo;
  logic [SW-1:0]         hi;
  logic                  done;
  logic [SW+SEQ_W-1:0]   cur_ext;

  // Effective window and count
  always_comb begin
    if (wsize_r == '0) begin
      win = WSIZE_W'(1);
    end else if (wsize_r > WSIZE_W'(WIN_CAP)) begin
      win = WSIZE_W'(WIN_CAP);
    end else begin
      win = wsize_r;
    end
    win_sw    = {{(SW-WSIZE_W){1'b0}}, win};
    count_eff = (count_r == '0) ? COUNT_W'(1) : count_r;
    cnt_ext   = {{SW{1'b0}}, count_eff};
    cnt       = cnt_ext[SW-1:0];
    ack_ext   = {{SW{1'b0}}, ack_r};
    ack_sw    = {1'b0, ack_ext[SEQ_BITS-1:0]};
  end

  // Acknowledgement arithmetic
  always_comb begin
    ack_ok   = active_r && flag_zero_r && (ack_sw >= base_r);
    top      = (ack_sw > cnt) ? cnt : ack_sw;
    retire   = (top >= base_r);
    top_p1   = top + SW'(1);
    edge_adv = edge_r + top_p1 - base_r;
  end

  // Send range for the plan step
  always_comb begin
    lo_a = old_edge_r + SW'(1);
    lo   = (lo_a < base_r) ? base_r : lo_a;
    hi   = (edge_r > cnt) ? cnt : edge_r;
    done = ok_r && (cmd_r == CMD_ACK) && (base_r > cnt);
  end

  assign cur_ext = {{SEQ_W{1'b0}}, cur_r};

  // Next-state logic
  always_comb begin
    wsize_nxt     = wsize_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    flag_zero_nxt = flag_zero_r;
    ack_nxt       = ack_r;
    base_nxt      = base_r;
    edge_nxt      = edge_r;
    old_edge_nxt  = old_edge_r;
    active_nxt    = active_r;
    ok_nxt        = ok_r;
    cur_nxt       = cur_r;
    hi_nxt        = hi_r;
    note_kind_nxt = note_kind_r;
    out_kind_nxt  = out_kind_r;
    out_seq_nxt   = out_seq_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;

    // register writes
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_WSIZE: wsize_nxt = cfg_wdata[WSIZE_W-1:0];
        REG_COUNT: count_nxt = cfg_wdata[COUNT_W-1:0];
        default:   count_nxt = count_r;
      endcase
    end

    // capture the item
    if (ctl.latch) begin
      cmd_nxt       = cmd_t'(in_cmd);
      flag_zero_nxt = (in_ack_flag == '0);
      ack_nxt       = in_ack_seq;
    end

    // update the window
    if (ctl.update) begin
      case (cmd_r)
        CMD_START: begin
          base_nxt     = SW'(1);
          edge_nxt     = win_sw;
          active_nxt   = 1'b1;
          old_edge_nxt = '0;
          ok_nxt       = 1'b1;
        end
        CMD_ACK: begin
          ok_nxt       = ack_ok;
          old_edge_nxt = edge_r;
          if (ack_ok && retire) begin
            base_nxt = top_p1;
            edge_nxt = edge_adv;
          end
        end
        CMD_TIMEOUT: begin
          ok_nxt       = active_r;
          old_edge_nxt = base_r - SW'(1);
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end

    // plan the results
    if (ctl.plan) begin
      cur_nxt       = lo;
      hi_nxt        = hi;
      note_kind_nxt = done ? KIND_DONE : KIND_NONE;
      if (done) active_nxt = 1'b0;
    end

    // load a transmit order
    if (ctl.emit_send) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_SEND;
      out_seq_nxt   = cur_ext[SEQ_W-1:0];
      out_last_nxt  = (cur_r == hi_r);
      cur_nxt       = cur_r + SW'(1);
    end

    // load a single note
    if (ctl.emit_note) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = note_kind_r;
      out_seq_nxt   = '0;
      out_last_nxt  = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r     <= WSIZE_RST;
      count_r     <= COUNT_RST;
      base_r      <= SW'(1);
      edge_r      <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wsize_r     <= wsize_nxt;
      count_r     <= count_nxt;
      base_r      <= base_nxt;
      edge_r      <= edge_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    flag_zero_r <= flag_zero_nxt;
    ack_r       <= ack_nxt;
    old_edge_r  <= old_edge_nxt;
    ok_r        <= ok_nxt;
    cur_r       <= cur_nxt;
    hi_r        <= hi_nxt;
    note_kind_r <= note_kind_nxt;
    out_kind_r  <= out_kind_nxt;
    out_seq_r   <= out_seq_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Status and outputs
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.at_last   = (cur_r == hi_r);
  assign stat.has_range = ok_r && !done && (lo <= hi);

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_send_seq = out_seq_r;
  assign out_last     = out_last_r;

  // Checks
  `ASSERT_IMP(a_load_slot_free, clk, rst_n, ctl.emit_send || ctl.emit_note, !out_valid_r || out_ready)
  `ASSERT_IMP(a_send_in_range, clk, rst_n, ctl.emit_send, cur_r <= hi_r)
  `ASSERT_ALWAYS(a_base_nonzero, clk, rst_n, base_r != '0)
  `ASSERT_IMP(a_window_span, clk, rst_n, active_r, (edge_r + SW'(1) - base_r) <= SW'(WIN_CAP))

endmodule

`default_nettype wire

@@ rtl/core/go_back_n_sender_window.sv @@
// Channel   Ports                              Moves
// in_ch     valid ready cmd ack_flag ack_seq   start, acknowledgement, timeout
// out_ch    valid ready kind send_seq last     transmit order, no action, complete
// cfg       cfg_we cfg_idx cfg_wdata           send window (0), segment total (1)
//
// One item at a time: the sequencer captures it, updates the window and plans,
// then emits its results in turn (n = 1 .. window). The result rate is set by the
// single output register: one transfer per cycle while the output is not stalled.
// Reset is synchronous, active low; the block takes items in the first cycle after.
// A stalled output holds the sequencer; a new item is taken as soon as the last
// result of the previous one sits in the output register.
`default_nettype none

module go_back_n_sender_window #(
  parameter int MAX_WINDOW = gbns_pkg::MAX_WINDOW_DEF,
  parameter int SEQ_BITS   = gbns_pkg::SEQ_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  gbns_in_if.sink                              in_ch,
  gbns_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [gbns_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [gbns_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gbns_pkg::*;

  ctl_t  ctl;
  stat_t stat;
  logic  in_ready;

  // Sequencer
  gbns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Window state and result register
  gbns_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .SEQ_BITS   (SEQ_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_cmd       (in_ch.cmd),
    .in_ack_flag  (in_ch.ack_flag),
    .in_ack_seq   (in_ch.ack_seq),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .ctl          (ctl),
    .stat         (stat),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_kind     (out_ch.kind),
    .out_send_seq (out_ch.send_seq),
    .out_last     (out_ch.last)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

@@ tb/go_back_n_sender_window_test.sv @@
`timescale 1ns / 1ps

module go_back_n_sender_window_test;
  import gbns_pkg::*;

  localparam int WIN_CAP     = MAX_WINDOW_DEF;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 26;

  typedef struct packed {
    cmd_t              cmd;
    logic [FLAG_W-1:0] flag;
    logic [SEQ_W-1:0]  seq;
  } link_event_t;

  typedef struct packed {
    kind_t            kind;
    logic [SEQ_W-1:0] seq;
    logic             last;
  } order_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gbns_in_if  in_bus ();
  gbns_out_if out_bus ();

  go_back_n_sender_window dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pending link events and the transmit orders they are due to cause
  link_event_t link_events[$];
  order_t      due_orders[$];

  int in_idle_pct  = 13;
  int out_idle_pct = 56;
  logic hold_kick  = 1'b0;
  int hold_left;
  int quiet_cycles;
  int error_count  = 0;

  // Window state as the block should hold it
  int unsigned reg_wsize = WSIZE_RST;
  int unsigned reg_count = COUNT_RST;
  int unsigned win_base  = 1;
  int unsigned win_edge  = 0;
  bit          win_open  = 1'b0;

  // Stimulus-side view of the transfer, used only to aim the generated events
  int unsigned tx_wsize = WSIZE_RST;
  int unsigned tx_count = COUNT_RST;
  int unsigned tx_base  = 1;
  bit          tx_open  = 1'b0;

  function automatic int unsigned win_span(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > WIN_CAP) return WIN_CAP;
    return raw;
  endfunction

  function automatic int unsigned count_span(int unsigned raw);
    return (raw == 0) ? 1 : raw;
  endfunction

  // Queue transmit orders lo..hi, clipped to the segment count and result limit
  function automatic int unsigned order_range(int unsigned lo, int unsigned hi,
                                              int unsigned n);
    int unsigned top;
    order_t o;
    top = (hi > count_span(reg_count)) ? count_span(reg_count) : hi;
    for (int unsigned s = lo; s <= top && n < RESULT_LIMIT; s++) begin
      o.kind = KIND_SEND;
      o.seq  = s[SEQ_W-1:0];
      o.last = 1'b0;
      due_orders.push_back(o);
      n++;
    end
    return n;
  endfunction

  // Advance the window for one accepted event and queue what it must emit
  function automatic void plan_orders(logic [CMD_W-1:0] cmd, logic [FLAG_W-1:0] flag,
                                      logic [SEQ_W-1:0] seq);
    int unsigned cnt, top, removed, old_edge, lo, n;
    order_t o;
    cnt = count_span(reg_count);
    n = 0;
    case (cmd)
      CMD_START: begin
        win_base = 1;
        win_edge = win_span(reg_wsize);
        win_open = 1'b1;
        n = order_range(win_base, win_edge, n);
      end
      CMD_ACK: begin
        if (win_open && flag == '0 && seq >= win_base) begin
          top = (seq > cnt) ? cnt : seq;
          removed = (top >= win_base) ? top - win_base + 1 : 0;
          old_edge = win_edge;
          win_base = (win_base + removed) & 32'h1FFFF;
          win_edge = (win_edge + removed) & 32'h1FFFF;
          lo = (old_edge + 1 < win_base) ? win_base : old_edge + 1;
          if (win_base > cnt) begin
            win_open = 1'b0;
            o.kind = KIND_DONE;
            o.seq  = '0;
            o.last = 1'b0;
            due_orders.push_back(o);
            n = 1;
          end else begin
            n = order_range(lo, win_edge, n);
          end
        end
      end
      CMD_TIMEOUT: begin
        if (win_open) n = order_range(win_base, win_edge, n);
      end
      default: ;
    endcase
    if (n == 0) begin
      o.kind = KIND_NONE;
      o.seq  = '0;
      o.last = 1'b0;
      due_orders.push_back(o);
    end
    o = due_orders.pop_back();
    o.last = 1'b1;
    due_orders.push_back(o);
  endfunction

  function automatic void log_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  // Driver: offer pending events, hold each until its transfer
  always @(posedge clk) begin : drive_link
    link_event_t ev;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        plan_orders(in_bus.cmd, in_bus.ack_flag, in_bus.ack_seq);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (link_events.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          ev = link_events.pop_front();
          in_bus.valid    <= 1'b1;
          in_bus.cmd      <= ev.cmd;
          in_bus.ack_flag <= ev.flag;
          in_bus.ack_seq  <= ev.seq;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest due order
  always @(posedge clk) begin : watch_orders
    order_t exp;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (due_orders.size() == 0) begin
          log_error($sformatf("unexpected result: kind %0d seq %0d last %0d",
                              out_bus.kind, out_bus.send_seq, out_bus.last));
        end else begin
          exp = due_orders.pop_front();
          if (out_bus.kind !== exp.kind || out_bus.send_seq !== exp.seq ||
              out_bus.last !== exp.last) begin
            log_error($sformatf(
              "mismatch: expected kind %0d seq %0d last %0d, got kind %0d seq %0d last %0d",
              exp.kind, exp.seq, exp.last, out_bus.kind, out_bus.send_seq, out_bus.last));
          end
        end
      end
      // Long hold-off on request, otherwise random stalls
      if (hold_kick) begin
        hold_left <= HOLD_CYCLES;
        out_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Watchdog: end the run when transfers stop on both channels
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL go_back_n_sender_window");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    if (idx == REG_WSIZE) begin
      reg_wsize = data[WSIZE_W-1:0];
      tx_wsize  = data[WSIZE_W-1:0];
    end else begin
      reg_count = data;
      tx_count  = data;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Queue one event and follow it on the stimulus side
  task automatic push_event(cmd_t cmd, logic [FLAG_W-1:0] flag, logic [SEQ_W-1:0] seq);
    link_event_t ev;
    int unsigned cnt, top;
    ev.cmd  = cmd;
    ev.flag = flag;
    ev.seq  = seq;
    link_events.push_back(ev);
    cnt = count_span(tx_count);
    if (cmd == CMD_START) begin
      tx_base = 1;
      tx_open = 1'b1;
    end else if (cmd == CMD_ACK && tx_open && flag == '0 && seq >= tx_base) begin
      top = (seq > cnt) ? cnt : seq;
      if (top >= tx_base) tx_base = top + 1;
      if (tx_base > cnt) tx_open = 1'b0;
    end
  endtask

  // Mostly well-aimed acknowledgements, with restarts, timeouts and noise
  task automatic add_traffic(int unsigned items);
    int unsigned r, w;
    repeat (items) begin
      r = $urandom_range(99);
      w = win_span(tx_wsize);
      if ((!tx_open && r < 85) || r < 3) begin
        push_event(CMD_START, 16'($urandom), 16'($urandom));
      end else if (r < 68) begin
        push_event(CMD_ACK, '0, 16'(tx_base - 1 + $urandom_range(1, w + 2)));
      end else if (r < 76) begin
        push_event(CMD_ACK, '0, 16'($urandom_range(0, tx_base - 1)));
      end else if (r < 85) begin
        push_event(CMD_TIMEOUT, 16'($urandom), 16'($urandom));
      end else if (r < 91) begin
        push_event(CMD_ACK, 16'($urandom_range(1, 16'hFFFF)),
                   16'(tx_base + $urandom_range(0, w)));
      end else begin
        push_event(cmd_t'($urandom_range(3)), ($urandom_range(1) != 0) ? '0 : 16'($urandom),
                   16'($urandom));
      end
    end
  endtask

  // Wait until every event is taken and every order has come out
  task automatic drain();
    do @(negedge clk);
    while (link_events.size() != 0 || in_bus.valid || due_orders.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    in_bus.valid    = 1'b0;
    in_bus.cmd      = CMD_START;
    in_bus.ack_flag = '0;
    in_bus.ack_seq  = '0;
    out_bus.ready   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Idle behavior and rejected events at reset settings
    push_event(CMD_ACK, '0, 16'd1);
    push_event(CMD_TIMEOUT, '0, '0);
    push_event(CMD_RSVD, 16'hFFFF, 16'hFFFF);
    push_event(CMD_START, '0, '0);
    push_event(CMD_ACK, '0, 16'd0);
    push_event(CMD_ACK, 16'hFFFF, 16'd1);
    push_event(CMD_ACK, '0, 16'hFFFF);
    drain();

    // Zero window taken as one; jump past the edge; restart while active
    write_reg(REG_WSIZE, 16'd0);
    write_reg(REG_COUNT, 16'd40);
    push_event(CMD_START, '0, '0);
    push_event(CMD_TIMEOUT, '0, '0);
    push_event(CMD_ACK, '0, 16'd1);
    push_event(CMD_ACK, '0, 16'd10);
    push_event(CMD_START, '0, '0);
    drain();

    // Oversized window saturates; full-width bursts
    write_reg(REG_WSIZE, 16'd127);
    write_reg(REG_COUNT, 16'd200);
    push_event(CMD_START, '0, '0);
    push_event(CMD_ACK, '0, 16'd30);
    push_event(CMD_TIMEOUT, '0, '0);
    drain();

    // Shrink the count mid-transfer, then acknowledge past it
    write_reg(REG_COUNT, 16'd50);
    push_event(CMD_TIMEOUT, '0, '0);
    push_event(CMD_ACK, '0, 16'hFFFF);
    drain();

    // Zero count taken as one
    write_reg(REG_WSIZE, 16'd64);
    write_reg(REG_COUNT, 16'd0);
    push_event(CMD_START, '0, '0);
    push_event(CMD_ACK, '0, 16'd1);
    drain();

    // Largest count reached in two acknowledgements
    write_reg(REG_WSIZE, 16'd1);
    write_reg(REG_COUNT, 16'hFFFF);
    push_event(CMD_START, '0, '0);
    push_event(CMD_ACK, '0, 16'hFFFE);
    push_event(CMD_ACK, '0, 16'hFFFF);
    drain();

    // Random phases: sender light/receiver heavy, swapped, then no idling
    for (int p = 0; p < PHASES; p++) begin
      @(posedge clk);
      in_idle_pct  <= (p < 3) ? 13 : ((p < 6) ? 56 : 0);
      out_idle_pct <= (p < 3) ? 56 : ((p < 6) ? 13 : 0);
      case (p)
        0: write_reg(REG_WSIZE, 16'd1);
        1: write_reg(REG_WSIZE, 16'd64);
        2: write_reg(REG_WSIZE, 16'd127);
        3: write_reg(REG_WSIZE, 16'd0);
        default: write_reg(REG_WSIZE, 16'($urandom_range(1, 64)));
      endcase
      case (p)
        4: write_reg(REG_COUNT, 16'd0);
        5: write_reg(REG_COUNT, 16'hFFFF);
        7: ;
        default: write_reg(REG_COUNT, 16'($urandom_range(1, 60)));
      endcase
      add_traffic(PHASE_ITEMS);
      // Stall the result side long enough for the block to back up its input
      if (p == 6) begin
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (due_orders.size() != 0) begin
      log_error($sformatf("%0d results never arrived", due_orders.size()));
    end
    if (error_count == 0) begin
      $display("PASS go_back_n_sender_window");
    end else begin
      $display("FAIL go_back_n_sender_window");
    end
    $finish;
  end

endmodule
